// ===== src/lct_pkg.sv =====
// Shared constants, types and offset functions of the label contour tracer.
package lct_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int LABEL_BITS = 16;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int CRD_BITS   = 8;
    localparam int DIM_BITS   = 9;
    localparam int SCRD_BITS  = 10;
    localparam int HALF_BITS  = 10;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STEP  = 2'd2;

    localparam logic [1:0] ST_POINT    = 2'd0;
    localparam logic [1:0] ST_FOUND    = 2'd1;
    localparam logic [1:0] ST_NOBORDER = 2'd2;
    localparam logic [1:0] ST_NOTRACE  = 2'd3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [2:0] RD_SCAN_C = 3'd0;
    localparam logic [2:0] RD_SCAN_N = 3'd1;
    localparam logic [2:0] RD_CUR    = 3'd2;
    localparam logic [2:0] RD_NP     = 3'd3;
    localparam logic [2:0] RD_SP1    = 3'd4;
    localparam logic [2:0] RD_NP1    = 3'd5;

    localparam logic [2:0] OK_START    = 3'd0;
    localparam logic [2:0] OK_NOBORDER = 3'd1;
    localparam logic [2:0] OK_NOTRACE  = 3'd2;
    localparam logic [2:0] OK_SIDE     = 3'd3;
    localparam logic [2:0] OK_CORNER   = 3'd4;

    typedef struct packed {
        logic       load_pix;
        logic       start_init;
        logic       scan_adv;
        logic       nidx_clr;
        logic       nidx_inc;
        logic       found;
        logic       stop;
        logic [2:0] rd_sel;
        logic       cap_cur;
        logic       cap_np;
        logic       cap_sp1;
        logic       cap_np1;
        logic       out_ld;
        logic [2:0] out_kind;
        logic       move;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic scan_hit;
        logic scan_last;
        logic nb_diff;
        logic nidx_last;
        logic corner;
        logic active;
    } t_stat;

    function automatic logic [SCRD_BITS-1:0] dr_side(input logic [1:0] s);
        case (s)
            2'd1:    dr_side = '1;
            2'd3:    dr_side = SCRD_BITS'(1);
            default: dr_side = '0;
        endcase
    endfunction

    function automatic logic [SCRD_BITS-1:0] dc_side(input logic [1:0] s);
        case (s)
            2'd0:    dc_side = '1;
            2'd2:    dc_side = SCRD_BITS'(1);
            default: dc_side = '0;
        endcase
    endfunction

    function automatic logic [SCRD_BITS-1:0] dr_corn(input logic [1:0] s);
        case (s)
            2'd0, 2'd1: dr_corn = '1;
            default:    dr_corn = SCRD_BITS'(1);
        endcase
    endfunction

    function automatic logic [SCRD_BITS-1:0] dc_corn(input logic [1:0] s);
        case (s)
            2'd0, 2'd3: dc_corn = '1;
            default:    dc_corn = SCRD_BITS'(1);
        endcase
    endfunction

endpackage

// ===== src/lct_datapath.sv =====
// Datapath: label memory, tracer registers, neighbor tests and result register.
module lct_datapath import lct_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [DIM_BITS-1:0]   i_cfg_data,
    input  logic [LABEL_BITS-1:0] i_label_value,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [1:0]            o_status,
    output logic [HALF_BITS-1:0]  o_row_half,
    output logic [HALF_BITS-1:0]  o_col_half,
    output logic [1:0]            o_edge_side,
    output logic                  o_is_corner,
    output logic [LABEL_BITS-1:0] o_neighbor_label,
    output logic                  o_contour_done
);

    logic [LABEL_BITS:0]   r_mem [DEPTH];
    logic [LABEL_BITS:0]   r_rdata;
    logic                  r_rin;

    logic [DIM_BITS-1:0]   r_cfg_w, r_cfg_h;
    logic [ADDR_BITS-1:0]  r_ptr;
    logic [LABEL_BITS-1:0] r_target;
    logic [CRD_BITS-1:0]   r_tr_row, r_tr_col, r_st_row, r_st_col;
    logic [1:0]            r_tr_side, r_st_side;
    logic                  r_active;
    logic [CRD_BITS-1:0]   r_sc_row, r_sc_col;
    logic [1:0]            r_nidx;
    logic [LABEL_BITS-1:0] r_cur, r_np, r_sp1, r_np1;
    logic                  r_sp1_in, r_np1_in;

    logic                  r_ov;
    logic [1:0]            r_o_status, r_o_side;
    logic [HALF_BITS-1:0]  r_o_row, r_o_col;
    logic                  r_o_corner, r_o_done;
    logic [LABEL_BITS-1:0] r_o_nb;

    logic [1:0]            n_o_status, n_o_side;
    logic [HALF_BITS-1:0]  n_o_row, n_o_col;
    logic                  n_o_corner, n_o_done;
    logic [LABEL_BITS-1:0] n_o_nb;

    logic [DIM_BITS-1:0]   w, h;
    logic [ADDR_BITS:0]    total, ptr_x, ptr_inc;
    logic [ADDR_BITS-1:0]  ptr_use;
    logic [SCRD_BITS-1:0]  tr_r, tr_c, r1, c1, rn1, cn1, rd_r, rd_c;
    logic [1:0]            s1;
    logic                  rd_in;
    logic [ADDR_BITS:0]    rd_prod;
    logic [ADDR_BITS-1:0]  rd_addr, wr_addr;
    logic [LABEL_BITS:0]   wr_data;
    logic                  wr_en;
    logic [LABEL_BITS-1:0] pix;
    logic                  corner, cm1, cm2, done;
    logic [CRD_BITS-1:0]   n_row, n_col;
    logic [1:0]            n_side;
    logic                  out_free;

    function automatic logic [ADDR_BITS-1:0] rd_addr_cur();
        logic [ADDR_BITS:0] p;
        p = (ADDR_BITS+1)'(r_tr_row * w) + (ADDR_BITS+1)'(r_tr_col);
        return p[ADDR_BITS-1:0];
    endfunction

    always_comb begin
        w = r_cfg_w;
        if (w < DIM_BITS'(3)) w = DIM_BITS'(3);
        if (w > DIM_BITS'(MAX_WIDTH)) w = DIM_BITS'(MAX_WIDTH);
        h = r_cfg_h;
        if (h < DIM_BITS'(3)) h = DIM_BITS'(3);
        if (h > DIM_BITS'(MAX_HEIGHT)) h = DIM_BITS'(MAX_HEIGHT);
    end

    assign total   = (ADDR_BITS+1)'(w * h);
    assign ptr_x   = ({1'b0, r_ptr} >= total) ? '0 : {1'b0, r_ptr};
    assign ptr_use = ptr_x[ADDR_BITS-1:0];
    assign ptr_inc = ptr_x + 1'b1;

    assign tr_r = SCRD_BITS'(r_tr_row);
    assign tr_c = SCRD_BITS'(r_tr_col);
    assign s1   = r_tr_side + 2'd1;
    assign r1   = tr_r + dr_side(s1);
    assign c1   = tr_c + dc_side(s1);
    assign rn1  = r1 + dr_side(r_tr_side);
    assign cn1  = c1 + dc_side(r_tr_side);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_SCAN_C: begin rd_r = SCRD_BITS'(r_sc_row); rd_c = SCRD_BITS'(r_sc_col); end
            RD_SCAN_N: begin
                rd_r = SCRD_BITS'(r_sc_row) + dr_side(r_nidx);
                rd_c = SCRD_BITS'(r_sc_col) + dc_side(r_nidx);
            end
            RD_CUR:    begin rd_r = tr_r; rd_c = tr_c; end
            RD_NP:     begin rd_r = tr_r + dr_side(r_tr_side); rd_c = tr_c + dc_side(r_tr_side); end
            RD_SP1:    begin rd_r = r1; rd_c = c1; end
            RD_NP1:    begin rd_r = rn1; rd_c = cn1; end
            default:   begin rd_r = tr_r; rd_c = tr_c; end
        endcase
    end

    assign rd_in   = !rd_r[SCRD_BITS-1] && !rd_c[SCRD_BITS-1] &&
                     (rd_r[DIM_BITS-1:0] < h) && (rd_c[DIM_BITS-1:0] < w);
    assign rd_prod = (ADDR_BITS+1)'(rd_r[CRD_BITS-1:0] * w) + (ADDR_BITS+1)'(rd_c[CRD_BITS-1:0]);
    assign rd_addr = rd_prod[ADDR_BITS-1:0];

    assign pix = r_rin ? r_rdata[LABEL_BITS-1:0] : '0;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ptr_use;
        wr_data = {1'b0, i_label_value};
        if (i_cmd.load_pix) begin
            wr_en = 1'b1;
        end else if (i_cmd.cap_cur) begin
            wr_en   = 1'b1;
            wr_addr = rd_addr_cur();
            wr_data = {1'b1, r_rdata[LABEL_BITS-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
        r_rin   <= rd_in;
    end

    assign corner = ((r_sp1 != r_cur) && (r_sp1 != r_np)) ||
                    ((r_np1 != r_cur) && (r_np1 != r_np));
    assign cm1    = r_sp1_in && (r_sp1 == r_cur);
    assign cm2    = r_np1_in && (r_np1 == r_cur);

    always_comb begin
        if (!cm1) begin
            n_row = r_tr_row; n_col = r_tr_col; n_side = s1;
        end else if (cm2) begin
            n_row = rn1[CRD_BITS-1:0]; n_col = cn1[CRD_BITS-1:0]; n_side = r_tr_side + 2'd3;
        end else begin
            n_row = r1[CRD_BITS-1:0]; n_col = c1[CRD_BITS-1:0]; n_side = r_tr_side;
        end
    end

    assign done     = (n_row == r_st_row) && (n_col == r_st_col) && (n_side == r_st_side);
    assign out_free = !r_ov || i_out_ready;

    always_comb begin
        o_stat.out_free  = out_free;
        o_stat.scan_hit  = !r_rdata[LABEL_BITS] && (r_rdata[LABEL_BITS-1:0] == r_target);
        o_stat.scan_last = ({1'b0, r_sc_col} == w - 1'b1) && ({1'b0, r_sc_row} == h - 2'd2);
        o_stat.nb_diff   = pix != r_target;
        o_stat.nidx_last = r_nidx == 2'd3;
        o_stat.corner    = corner;
        o_stat.active    = r_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= DIM_BITS'(MAX_WIDTH);
            r_cfg_h   <= DIM_BITS'(MAX_HEIGHT);
            r_ptr     <= '0;
            r_target  <= '0;
            r_tr_row  <= '0;
            r_tr_col  <= '0;
            r_tr_side <= '0;
            r_st_row  <= '0;
            r_st_col  <= '0;
            r_st_side <= '0;
            r_active  <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WIDTH) r_cfg_w <= i_cfg_data;
                if (i_cfg_idx == CFG_HEIGHT) r_cfg_h <= i_cfg_data;
            end
            if (i_cmd.load_pix) begin
                r_ptr <= (ptr_inc >= total) ? '0 : ptr_inc[ADDR_BITS-1:0];
            end
            if (i_cmd.start_init) r_target <= i_label_value;
            if (i_cmd.found) begin
                r_tr_row  <= r_sc_row;
                r_tr_col  <= r_sc_col;
                r_tr_side <= r_nidx;
                r_st_row  <= r_sc_row;
                r_st_col  <= r_sc_col;
                r_st_side <= r_nidx;
                r_active  <= 1'b1;
            end
            if (i_cmd.stop) r_active <= 1'b0;
            if (i_cmd.move) begin
                r_tr_row  <= n_row;
                r_tr_col  <= n_col;
                r_tr_side <= n_side;
                if (done) r_active <= 1'b0;
            end
            if (i_cmd.out_ld) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_comb begin
        n_o_status = ST_POINT;
        n_o_row    = '0;
        n_o_col    = '0;
        n_o_side   = '0;
        n_o_corner = 1'b0;
        n_o_nb     = '0;
        n_o_done   = 1'b0;
        case (i_cmd.out_kind)
            OK_START: begin
                n_o_status = ST_FOUND;
                n_o_row    = {1'b0, r_tr_row, 1'b1};
                n_o_col    = {1'b0, r_tr_col, 1'b1};
                n_o_side   = r_tr_side;
            end
            OK_NOBORDER: n_o_status = ST_NOBORDER;
            OK_NOTRACE:  n_o_status = ST_NOTRACE;
            OK_SIDE: begin
                n_o_row  = {1'b0, r_tr_row, 1'b1} + dr_side(r_tr_side);
                n_o_col  = {1'b0, r_tr_col, 1'b1} + dc_side(r_tr_side);
                n_o_side = r_tr_side;
                n_o_nb   = r_np;
                n_o_done = !corner && done;
            end
            OK_CORNER: begin
                n_o_row    = {1'b0, r_tr_row, 1'b1} + dr_corn(r_tr_side);
                n_o_col    = {1'b0, r_tr_col, 1'b1} + dc_corn(r_tr_side);
                n_o_side   = r_tr_side;
                n_o_corner = 1'b1;
                n_o_done   = done;
            end
            default: n_o_status = ST_NOTRACE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_init) begin
            r_sc_row <= CRD_BITS'(1);
            r_sc_col <= CRD_BITS'(1);
        end else if (i_cmd.scan_adv) begin
            if ({1'b0, r_sc_col} == w - 1'b1) begin
                r_sc_col <= CRD_BITS'(1);
                r_sc_row <= r_sc_row + 1'b1;
            end else begin
                r_sc_col <= r_sc_col + 1'b1;
            end
        end
        if (i_cmd.nidx_clr) r_nidx <= '0;
        else if (i_cmd.nidx_inc) r_nidx <= r_nidx + 2'd1;
        if (i_cmd.cap_cur) r_cur <= r_rdata[LABEL_BITS-1:0];
        if (i_cmd.cap_np) r_np <= pix;
        if (i_cmd.cap_sp1) begin
            r_sp1    <= pix;
            r_sp1_in <= r_rin;
        end
        if (i_cmd.cap_np1) begin
            r_np1    <= pix;
            r_np1_in <= r_rin;
        end
        if (i_cmd.out_ld) begin
            r_o_status <= n_o_status;
            r_o_row    <= n_o_row;
            r_o_col    <= n_o_col;
            r_o_side   <= n_o_side;
            r_o_corner <= n_o_corner;
            r_o_nb     <= n_o_nb;
            r_o_done   <= n_o_done;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_status         = r_o_status;
    assign o_row_half       = r_o_row;
    assign o_col_half       = r_o_col;
    assign o_edge_side      = r_o_side;
    assign o_is_corner      = r_o_corner;
    assign o_neighbor_label = r_o_nb;
    assign o_contour_done   = r_o_done;

endmodule

// ===== src/lct_controller.sv =====
// Controller: sequences loads, the start scan and the trace step.
module lct_controller import lct_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_func,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SC      = 4'd1;
    localparam logic [3:0] S_SCW     = 4'd2;
    localparam logic [3:0] S_SN      = 4'd3;
    localparam logic [3:0] S_SNW     = 4'd4;
    localparam logic [3:0] S_FOUND   = 4'd5;
    localparam logic [3:0] S_NOBRD   = 4'd6;
    localparam logic [3:0] S_NOTRACE = 4'd7;
    localparam logic [3:0] S_T0      = 4'd8;
    localparam logic [3:0] S_T1      = 4'd9;
    localparam logic [3:0] S_T2      = 4'd10;
    localparam logic [3:0] S_T3      = 4'd11;
    localparam logic [3:0] S_T4      = 4'd12;
    localparam logic [3:0] S_SIDE    = 4'd13;
    localparam logic [3:0] S_CORN    = 4'd14;
    localparam logic [3:0] S_MOVE    = 4'd15;

    logic [3:0] r_state, n_state;
    logic       acc;

    assign o_in_ready = r_state == S_IDLE;
    assign acc        = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_CUR;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_func)
                        FUNC_LOAD:  o_cmd.load_pix = 1'b1;
                        FUNC_START: begin
                            o_cmd.start_init = 1'b1;
                            n_state = S_SC;
                        end
                        FUNC_STEP:  n_state = i_stat.active ? S_T0 : S_NOTRACE;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_SC: begin
                o_cmd.rd_sel = RD_SCAN_C;
                n_state = S_SCW;
            end
            S_SCW: begin
                if (i_stat.scan_hit) begin
                    o_cmd.nidx_clr = 1'b1;
                    n_state = S_SN;
                end else if (i_stat.scan_last) begin
                    n_state = S_NOBRD;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    n_state = S_SC;
                end
            end
            S_SN: begin
                o_cmd.rd_sel = RD_SCAN_N;
                n_state = S_SNW;
            end
            S_SNW: begin
                if (i_stat.nb_diff) begin
                    o_cmd.found = 1'b1;
                    n_state = S_FOUND;
                end else if (!i_stat.nidx_last) begin
                    o_cmd.nidx_inc = 1'b1;
                    n_state = S_SN;
                end else if (i_stat.scan_last) begin
                    n_state = S_NOBRD;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    n_state = S_SC;
                end
            end
            S_FOUND: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = OK_START;
                    n_state = S_IDLE;
                end
            end
            S_NOBRD: begin
                o_cmd.stop = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = OK_NOBORDER;
                    n_state = S_IDLE;
                end
            end
            S_NOTRACE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = OK_NOTRACE;
                    n_state = S_IDLE;
                end
            end
            S_T0: begin
                o_cmd.rd_sel = RD_CUR;
                n_state = S_T1;
            end
            S_T1: begin
                o_cmd.cap_cur = 1'b1;
                o_cmd.rd_sel  = RD_NP;
                n_state = S_T2;
            end
            S_T2: begin
                o_cmd.cap_np = 1'b1;
                o_cmd.rd_sel = RD_SP1;
                n_state = S_T3;
            end
            S_T3: begin
                o_cmd.cap_sp1 = 1'b1;
                o_cmd.rd_sel  = RD_NP1;
                n_state = S_T4;
            end
            S_T4: begin
                o_cmd.cap_np1 = 1'b1;
                n_state = S_SIDE;
            end
            S_SIDE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = OK_SIDE;
                    n_state = i_stat.corner ? S_CORN : S_MOVE;
                end
            end
            S_CORN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = OK_CORNER;
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/label_contour_tracer_core.sv =====
// Top level of the label contour tracer: controller plus datapath.
// Load transaction: no result. Step transaction: four reads of the single label-memory
// read port, then the side point and, on a corner, the corner point, then the move.
// Start transaction: each scanned pixel and each neighbor is read and then tested.
// Synchronous active-low reset clears control state; label memory is not cleared.
module label_contour_tracer_core import lct_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [DIM_BITS-1:0]   i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_func,
    input  logic [LABEL_BITS-1:0] i_label_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [HALF_BITS-1:0]  o_row_half,
    output logic [HALF_BITS-1:0]  o_col_half,
    output logic [1:0]            o_edge_side,
    output logic                  o_is_corner,
    output logic [LABEL_BITS-1:0] o_neighbor_label,
    output logic                  o_contour_done
);

    t_cmd  cmd;
    t_stat stat;

    lct_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_func),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lct_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_label_value    (i_label_value),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_row_half       (o_row_half),
        .o_col_half       (o_col_half),
        .o_edge_side      (o_edge_side),
        .o_is_corner      (o_is_corner),
        .o_neighbor_label (o_neighbor_label),
        .o_contour_done   (o_contour_done)
    );

endmodule

// ===== test/label_contour_tracer_core_tb.sv =====
// Testbench for label_contour_tracer_core: scoreboard with contour predictor, random drive.
`timescale 1ns / 100ps

module label_contour_tracer_core_tb;
    import lct_pkg::*;

    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct {
        logic [1:0]  status;
        logic [9:0]  row_half;
        logic [9:0]  col_half;
        logic [1:0]  side;
        logic        corner;
        logic [15:0] nb_label;
        logic        done;
    } t_point;

    class contour_scoreboard;
        logic [16:0] pix_mem [];
        int wid = 256, hgt = 256;
        int load_ptr, tgt_label;
        int tr, tc, ts, sr, scol, ss;
        bit active;
        t_point pending [$];
        int errors;
        int results_seen;
        int row_step [4] = '{0, -1, 0, 1};
        int col_step [4] = '{-1, 0, 1, 0};
        int row_corn [4] = '{-1, -1, 1, 1};
        int col_corn [4] = '{-1, 1, 1, -1};

        function new();
            pix_mem = new[65536];
        endfunction

        function int lab(int r, int c);
            if (r < 0 || c < 0 || r >= hgt || c >= wid) return 0;
            return int'(pix_mem[r * wid + c][15:0]);
        endfunction

        function bit can_move(int r, int c, int l);
            return r >= 0 && c >= 0 && r < hgt && c < wid && lab(r, c) == l;
        endfunction

        function void push(logic [1:0] st, int rh, int ch, int sd, bit cor, int nb);
            t_point p;
            p.status = st;
            p.row_half = rh[9:0];
            p.col_half = ch[9:0];
            p.side = sd[1:0];
            p.corner = cor;
            p.nb_label = nb[15:0];
            p.done = 1'b0;
            pending.push_back(p);
        endfunction

        function void set_dim(logic idx, int v);
            if (idx == CFG_WIDTH) wid = v;
            else hgt = v;
        endfunction

        function void note_input(logic [1:0] f, logic [15:0] v);
            int total, r, c, s, s1, r1, c1, rn1, cn1, cur, np, sp1, np1;
            bit cor;
            logic [16:0] w;
            total = wid * hgt;
            case (f)
                FUNC_LOAD: begin
                    if (load_ptr >= total) load_ptr = 0;
                    pix_mem[load_ptr] = {1'b0, v};
                    load_ptr++;
                    if (load_ptr >= total) load_ptr = 0;
                end
                FUNC_START: begin
                    tgt_label = v;
                    for (r = 1; r < hgt - 1; r++) begin
                        for (c = 1; c < wid; c++) begin
                            w = pix_mem[r * wid + c];
                            if (w[16] || int'(w[15:0]) != tgt_label) continue;
                            for (s = 0; s < 4; s++) begin
                                if (lab(r + row_step[s], c + col_step[s]) != tgt_label) begin
                                    tr = r; tc = c; ts = s;
                                    sr = r; scol = c; ss = s;
                                    active = 1;
                                    push(ST_FOUND, 2 * r + 1, 2 * c + 1, s, 0, 0);
                                    return;
                                end
                            end
                        end
                    end
                    active = 0;
                    push(ST_NOBORDER, 0, 0, 0, 0, 0);
                end
                FUNC_STEP: begin
                    if (!active) begin
                        push(ST_NOTRACE, 0, 0, 0, 0, 0);
                        return;
                    end
                    r = tr; c = tc; s = ts;
                    pix_mem[r * wid + c][16] = 1'b1;
                    cur = lab(r, c);
                    np = lab(r + row_step[s], c + col_step[s]);
                    push(ST_POINT, 2 * r + 1 + row_step[s], 2 * c + 1 + col_step[s], s, 0, np);
                    s1 = (s + 1) % 4;
                    r1 = r + row_step[s1];
                    c1 = c + col_step[s1];
                    rn1 = r1 + row_step[s];
                    cn1 = c1 + col_step[s];
                    sp1 = lab(r1, c1);
                    np1 = lab(rn1, cn1);
                    cor = (sp1 != cur && sp1 != np) || (np1 != cur && np1 != np);
                    if (cor) push(ST_POINT, 2 * r + 1 + row_corn[s], 2 * c + 1 + col_corn[s],
                                  s, 1, 0);
                    if (!can_move(r1, c1, cur)) begin
                        s = s1;
                    end else if (can_move(rn1, cn1, cur)) begin
                        r = rn1; c = cn1; s = (s + 3) % 4;
                    end else begin
                        r = r1; c = c1;
                    end
                    tr = r; tc = c; ts = s;
                    if (r == sr && c == scol && s == ss) begin
                        pending[pending.size() - 1].done = 1'b1;
                        active = 0;
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check(t_point got);
            t_point e;
            results_seen++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result st=%0d r=%0d c=%0d",
                                 got.status, got.row_half, got.col_half));
                return;
            end
            e = pending.pop_front();
            if (got.status != e.status || got.row_half != e.row_half ||
                got.col_half != e.col_half || got.side != e.side ||
                got.corner != e.corner || got.nb_label != e.nb_label || got.done != e.done)
                report($sformatf("got st%0d r%0d c%0d s%0d k%0d n%h d%0d exp st%0d r%0d c%0d s%0d k%0d n%h d%0d",
                    got.status, got.row_half, got.col_half, got.side, got.corner,
                    got.nb_label, got.done, e.status, e.row_half, e.col_half, e.side,
                    e.corner, e.nb_label, e.done));
        endtask
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_cfg_we = 0;
    logic                  i_cfg_idx = 0;
    logic [DIM_BITS-1:0]   i_cfg_data = '0;
    logic                  i_in_valid = 0;
    logic                  o_in_ready;
    logic [1:0]            i_func = FUNC_LOAD;
    logic [LABEL_BITS-1:0] i_label_value = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 0;
    logic [1:0]            o_status;
    logic [HALF_BITS-1:0]  o_row_half;
    logic [HALF_BITS-1:0]  o_col_half;
    logic [1:0]            o_edge_side;
    logic                  o_is_corner;
    logic [LABEL_BITS-1:0] o_neighbor_label;
    logic                  o_contour_done;

    contour_scoreboard sb = new();
    bit idle_en = 1;
    int sent_items;
    int palette [4];
    int rect_r0 [3], rect_r1 [3], rect_c0 [3], rect_c1 [3], rect_lab [3];

    label_contour_tracer_core u_top (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    initial begin
        #20ms;
        $display("label_contour_tracer_core_tb failed");
        $finish;
    end

    always @(posedge i_clk) begin
        t_point got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.status = o_status;
            got.row_half = o_row_half;
            got.col_half = o_col_half;
            got.side = o_edge_side;
            got.corner = o_is_corner;
            got.nb_label = o_neighbor_label;
            got.done = o_contour_done;
            sb.check(got);
        end
    end

    int stall_left;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send(logic [1:0] f, logic [15:0] v);
        if (idle_en && $urandom_range(0, 9) == 0) repeat ($urandom_range(1, 14)) @(negedge i_clk);
        i_func = f;
        i_label_value = v;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(f, v);
        sent_items++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic idx, int v);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = v[DIM_BITS-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_dim(idx, v);
    endtask

    function automatic int pattern_label(int p);
        int r, c, l;
        r = p / sb.wid;
        c = p % sb.wid;
        l = palette[0];
        for (int k = 0; k < 3; k++)
            if (r >= rect_r0[k] && r <= rect_r1[k] && c >= rect_c0[k] && c <= rect_c1[k])
                l = rect_lab[k];
        return l;
    endfunction

    task automatic load_image(int w, int h);
        int a, b;
        drain();
        write_cfg(CFG_WIDTH, w);
        write_cfg(CFG_HEIGHT, h);
        palette[0] = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 65535);
        for (int k = 1; k < 4; k++) palette[k] = $urandom_range(0, 65535);
        for (int k = 0; k < 3; k++) begin
            a = $urandom_range(0, h - 1); b = $urandom_range(0, h - 1);
            rect_r0[k] = a < b ? a : b; rect_r1[k] = a < b ? b : a;
            a = $urandom_range(0, w - 1); b = $urandom_range(0, w - 1);
            rect_c0[k] = a < b ? a : b; rect_c1[k] = a < b ? b : a;
            rect_lab[k] = palette[$urandom_range(1, 3)];
        end
        for (int k = 0; k < w * h; k++) begin
            if ($urandom_range(0, 39) == 0) send(FUNC_LOAD, 16'($urandom_range(0, 65535)));
            else send(FUNC_LOAD, 16'(pattern_label(sb.load_ptr)));
        end
    endtask

    task automatic trace_phase(int w, int h, bit pause_mid);
        int n;
        load_image(w, h);
        repeat ($urandom_range(2, 4)) begin
            send(FUNC_START, $urandom_range(0, 7) == 0 ? 16'($urandom_range(0, 65535))
                                                       : 16'(palette[$urandom_range(0, 3)]));
            n = $urandom_range(4, 2 * (w + h) + 8);
            if (n > 60) n = 60;
            for (int k = 0; k < n; k++) begin
                case ($urandom_range(0, 39))
                    0: send(FUNC_NONE, 16'($urandom_range(0, 65535)));
                    1: send(FUNC_LOAD, 16'(pattern_label(sb.load_ptr)));
                    2: send(FUNC_START, 16'(palette[$urandom_range(0, 3)]));
                    default: send(FUNC_STEP, 16'($urandom_range(0, 65535)));
                endcase
                if (pause_mid && k == n / 2) drain();
            end
        end
    endtask

    initial begin
        int w, h;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        write_cfg(CFG_WIDTH, 3);
        write_cfg(CFG_HEIGHT, 3);
        send(FUNC_STEP, 16'h0);
        for (int k = 0; k < 9; k++) send(FUNC_LOAD, k == 4 ? 16'hFFFF : 16'h0000);
        send(FUNC_START, 16'hFFFF);
        repeat (5) send(FUNC_STEP, 16'hFFFF);
        send(FUNC_START, 16'h1234);
        send(FUNC_NONE, 16'hFFFF);
        send(FUNC_START, 16'h0000);
        repeat (6) send(FUNC_STEP, 16'h0000);

        trace_phase(256, 3, 0);
        trace_phase(5, 4, 1);
        while (sent_items < 1300) begin
            case ($urandom_range(0, 9))
                0: begin w = $urandom_range(3, 12); h = $urandom_range(3, 12); end
                default: begin w = $urandom_range(3, 8); h = $urandom_range(3, 8); end
            endcase
            if (sent_items > 1150) idle_en = 0;
            trace_phase(w, h, 0);
        end

        drain();
        repeat (30) @(negedge i_clk);
        if (sb.errors == 0) $display("label_contour_tracer_core_tb passed");
        else $display("label_contour_tracer_core_tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/lct_pkg.sv
src/lct_datapath.sv
src/lct_controller.sv
src/label_contour_tracer_core.sv
test/label_contour_tracer_core_tb.sv
